FILE: src/reversible_deque_engine_top_macros.svh
// ----------------------------------------------------------------------------
// reversible_deque_engine_top_macros
// Assertion macros used by the deque engine RTL.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_DEQUE_ENGINE_TOP_MACROS_SVH
`define REVERSIBLE_DEQUE_ENGINE_TOP_MACROS_SVH

// clocked assertion, masked while reset is held
`define RDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define RDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Types and constants of the reversible deque engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

  localparam int RDQ_STORE_DEPTH  = 1024;
  localparam int RDQ_ELEMENT_BITS = 8;

  localparam int REQ_W = 3;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DRAIN  = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_READ
  } rdq_state_t;

endpackage

`default_nettype wire

FILE: src/reversible_deque_engine_top.sv
// Output: a non-drain word gives its status word in the cycle after acceptance;
//   a drain that returns an element goes through the element RAM read port and S_READ.
// Throughput: one word per cycle while out_tready frees the output register;
//   a returning drain holds input while the RAM read completes in S_READ.
// Reset: synchronous, active low; pointers, count, direction and error clear.
//   The element store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// reversible_deque_engine_top
// Ring-buffer deque with direction flag, elements in a single-port RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reversible_deque_engine_top_macros.svh"

module reversible_deque_engine_top
  import rdq_pkg::*;
#(
  parameter int STORE_DEPTH  = RDQ_STORE_DEPTH,
  parameter int ELEMENT_BITS = RDQ_ELEMENT_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [ELEMENT_BITS-1:0] load_value
  input  wire logic [((ELEMENT_BITS+7)/8)*8-1:0]   in_tdata,
  // [2:0] req_type
  input  wire logic [REQ_W-1:0]                    in_tuser,

  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // read_value, error_flag, overflow_flag, held_count (low to high)
  output logic [((ELEMENT_BITS+2+$clog2(STORE_DEPTH+1)+7)/8)*8-1:0] out_tdata,
  // [0] read_valid
  output logic [0:0]                               out_tuser,
  // last_of_run
  output logic                                     out_tlast
);

  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(STORE_DEPTH + 1);
  localparam int OUT_BITS    = ELEMENT_BITS + 2 + CW;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (AW+1)'(STORE_DEPTH)) begin
      sum = sum - (AW+1)'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  rdq_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          err_r, err_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ELEMENT_BITS-1:0] out_value_r, out_value_nxt;
  logic                    out_rvalid_r, out_rvalid_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;
  logic                    out_ovf_r, out_ovf_nxt;
  logic [CW-1:0]           out_count_r, out_count_nxt;

  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  logic [ELEMENT_BITS-1:0] mem_rdata;

  logic in_acc;
  logic drain_go;
  logic ovf;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  rdq_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_tdata[ELEMENT_BITS-1:0]),
    .rdata (mem_rdata)
  );

  // Only one RAM access per word and no access in S_READ, so a read never
  // meets a write to the same entry: no forwarding needed.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    err_nxt        = err_r;
    mem_we         = 1'b0;
    mem_addr       = head_r;
    drain_go       = 1'b0;
    ovf            = 1'b0;

    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_rvalid_nxt = out_rvalid_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    out_ovf_nxt    = out_ovf_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
              rev_nxt   = 1'b0;
              err_nxt   = 1'b0;
            end
            REQ_LOAD: begin
              if (count_r == CW'(STORE_DEPTH)) begin
                ovf = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = ring_add(head_r, count_r[AW-1:0]);
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_TOGGLE: begin
              rev_nxt = !rev_r;
            end
            REQ_DELETE: begin
              if (!err_r) begin
                if (count_r == '0) begin
                  err_nxt = 1'b1;
                end else begin
                  if (!rev_r) begin
                    head_nxt = ring_add(head_r, AW'(1));
                  end
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            REQ_DRAIN: begin
              if (!err_r && count_r != '0) begin
                drain_go  = 1'b1;
                mem_addr  = rev_r ? ring_add(head_r, count_r[AW-1:0] - AW'(1)) : head_r;
                if (!rev_r) begin
                  head_nxt = ring_add(head_r, AW'(1));
                end
                count_nxt = count_r - CW'(1);
                state_nxt = S_READ;
              end
            end
            default: begin
            end
          endcase

          out_valid_nxt  = !drain_go;
          out_value_nxt  = '0;
          out_rvalid_nxt = 1'b0;
          out_last_nxt   = drain_go && (count_nxt == '0);
          out_err_nxt    = err_nxt;
          out_ovf_nxt    = ovf;
          out_count_nxt  = count_nxt;
        end
      end
      S_READ: begin
        out_value_nxt  = mem_rdata;
        out_rvalid_nxt = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_count_r, out_ovf_r, out_err_r, out_value_r});
  assign out_tuser  = out_rvalid_r;
  assign out_tlast  = out_last_r;

  `RDQ_ASSERT(a_count_bound, count_r <= CW'(STORE_DEPTH), "element count beyond depth")
  `RDQ_ASSERT(a_head_bound, head_r < AW'(STORE_DEPTH) || AW'(STORE_DEPTH) == '0,
              "head pointer beyond depth")
  `RDQ_ASSERT(a_read_slot_free, (state_r == S_READ) |-> !out_valid_r,
              "output register busy when RAM data returns")
  `RDQ_ASSERT(a_read_one_cycle, (state_r == S_READ) |=> (state_r == S_IDLE && out_valid_r),
              "drain read did not complete in one cycle")
  `RDQ_ASSERT_ALWAYS(a_no_accept_in_read, (state_r == S_READ) |-> !in_tready,
                     "input accepted during RAM read")

endmodule

`default_nettype wire

FILE: src/rdq_ram.sv
// ----------------------------------------------------------------------------
// rdq_ram
// Generic single-port RAM, registered read, no reset on the array.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire
